// ===== sv/lcr_pkg.sv =====
// Shared types and constants for the line clip rectangle unit.
// No dependencies; imported by lcr_div and line_clip_rectangle_unit.
`default_nettype none

package lcr_pkg;

  localparam int unsigned CoordWidth     = 24;
  localparam int unsigned RatioFracBits  = 16;
  localparam int unsigned DeltaWidth     = CoordWidth + 1;
  localparam int unsigned CfgIndexWidth  = 3;
  localparam int unsigned NumLanes       = 4;

  localparam logic [CfgIndexWidth-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_TOP    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RIGHT  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_BOTTOM = 3'd3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DeltaWidth-1:0] delta_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } segment_t;

  typedef struct packed {
    logic   visible;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } result_t;

  typedef struct packed {
    logic zero;
    logic pneg;
    logic qneg;
    logic sat;
  } lane_flags_t;

  typedef struct packed {
    coord_t      sx;
    coord_t      sy;
    delta_t      dx;
    delta_t      dy;
    lane_flags_t [NumLanes-1:0] flags;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/lcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Requires num < 2*den; depends on lcr_pkg.
`default_nettype none

module lcr_div #(
  parameter int unsigned MAG_W = lcr_pkg::DeltaWidth,
  parameter int unsigned RF    = lcr_pkg::RatioFracBits
) (
  input  wire logic             clk_i,
  input  wire logic [MAG_W-1:0] num_i,
  input  wire logic [MAG_W-1:0] den_i,
  output logic      [RF:0]      quo_o
);
  import lcr_pkg::*;

  localparam int unsigned Depth = RF + 1;

  logic [MAG_W:0]   rem_q [Depth];
  logic [MAG_W-1:0] den_q [Depth];
  logic [RF:0]      quo_q [Depth];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Depth; k++) begin
      logic [MAG_W:0]   rem_in;
      logic [MAG_W-1:0] den_in;
      logic [RF:0]      quo_in;
      logic [MAG_W+1:0] diff;
      if (k == 0) begin
        rem_in = {1'b0, num_i};
        den_in = den_i;
        quo_in = '0;
      end else begin
        rem_in = {rem_q[k-1][MAG_W-1:0], 1'b0};
        den_in = den_q[k-1];
        quo_in = quo_q[k-1];
      end
      diff = {1'b0, rem_in} - {2'b00, den_in};
      rem_q[k] <= diff[MAG_W+1] ? rem_in : diff[MAG_W:0];
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[RF-1:0], ~diff[MAG_W+1]};
    end
  end

  assign quo_o = quo_q[Depth-1];

endmodule

`default_nettype wire

// ===== sv/line_clip_rectangle_unit.sv =====
// Liang-Barsky segment clipper against a configured rectangle.
// One segment per cycle; the four ratio dividers are bit-per-stage pipelines that set
// the depth. busy stays low. Reset clears valid bits and the clip registers to zero.
// Depends on lcr_pkg, lcr_div.
`default_nettype none

module line_clip_rectangle_unit #(
  parameter int unsigned RATIO_FRAC_BITS = lcr_pkg::RatioFracBits
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire lcr_pkg::segment_t                   segment_i,
  output logic                                     strobe_o,
  output lcr_pkg::result_t                         result_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [lcr_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire lcr_pkg::coord_t                     cfg_data_i
);
  import lcr_pkg::*;

  localparam int unsigned RF    = RATIO_FRAC_BITS;
  localparam int unsigned DW    = DeltaWidth;
  localparam int unsigned RW    = RF + 3;
  localparam int unsigned PW    = DW + RW;
  localparam int unsigned Depth = RF + 1;

  localparam logic signed [RW-1:0] TOne = RW'(1) << RF;
  localparam logic [RF+1:0]        SatMag = (RF+2)'((RF+2)'(1) << RF) + (RF+2)'(1);
  localparam logic signed [PW-1:0] Half = PW'(1) << (RF-1);

  coord_t clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_right_q  <= '0;
      clip_bottom_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LEFT:   clip_left_q   <= cfg_data_i;
        CFG_TOP:    clip_top_q    <= cfg_data_i;
        CFG_RIGHT:  clip_right_q  <= cfg_data_i;
        CFG_BOTTOM: clip_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: deltas and boundary distances
  logic   s1_valid_q;
  coord_t s1_sx_q, s1_sy_q;
  delta_t s1_dx_q, s1_dy_q;
  delta_t s1_p_q [NumLanes];
  delta_t s1_q_q [NumLanes];

  logic   in_fire;
  delta_t dx_d, dy_d;
  assign in_fire = start && !busy;
  assign dx_d = DW'(segment_i.end_x) - DW'(segment_i.start_x);
  assign dy_d = DW'(segment_i.end_y) - DW'(segment_i.start_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sx_q   <= segment_i.start_x;
    s1_sy_q   <= segment_i.start_y;
    s1_dx_q   <= dx_d;
    s1_dy_q   <= dy_d;
    s1_p_q[0] <= -dx_d;
    s1_p_q[1] <= dx_d;
    s1_p_q[2] <= -dy_d;
    s1_p_q[3] <= dy_d;
    s1_q_q[0] <= DW'(segment_i.start_x) - DW'(clip_left_q);
    s1_q_q[1] <= DW'(clip_right_q) - DW'(segment_i.start_x);
    s1_q_q[2] <= DW'(segment_i.start_y) - DW'(clip_top_q);
    s1_q_q[3] <= DW'(clip_bottom_q) - DW'(segment_i.start_y);
  end

  // stage 2: magnitudes and flags
  logic        s2_valid_q;
  side_t       s2_side_q;
  logic [DW-1:0] s2_aq_q [NumLanes];
  logic [DW-1:0] s2_ap_q [NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q.sx <= s1_sx_q;
    s2_side_q.sy <= s1_sy_q;
    s2_side_q.dx <= s1_dx_q;
    s2_side_q.dy <= s1_dy_q;
    for (int i = 0; i < NumLanes; i++) begin
      logic [DW-1:0] aq, ap;
      aq = s1_q_q[i][DW-1] ? DW'(-s1_q_q[i]) : DW'(s1_q_q[i]);
      ap = s1_p_q[i][DW-1] ? DW'(-s1_p_q[i]) : DW'(s1_p_q[i]);
      s2_aq_q[i] <= aq;
      s2_ap_q[i] <= ap;
      s2_side_q.flags[i].zero <= (s1_p_q[i] == '0);
      s2_side_q.flags[i].pneg <= s1_p_q[i][DW-1];
      s2_side_q.flags[i].qneg <= s1_q_q[i][DW-1];
      s2_side_q.flags[i].sat  <= ({1'b0, aq} >= {ap, 1'b0});
    end
  end

  // divider stages
  logic [RF:0] quo [NumLanes];

  for (genvar g = 0; g < NumLanes; g++) begin : g_div
    lcr_div #(
      .MAG_W (DW),
      .RF    (RF)
    ) u_div (
      .clk_i (clk_i),
      .num_i (s2_aq_q[g]),
      .den_i (s2_ap_q[g]),
      .quo_o (quo[g])
    );
  end

  logic  dv_valid_q [Depth];
  side_t dv_side_q  [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) begin
        dv_valid_q[k] <= 1'b0;
      end
    end else begin
      dv_valid_q[0] <= s2_valid_q;
      for (int k = 1; k < Depth; k++) begin
        dv_valid_q[k] <= dv_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= s2_side_q;
    for (int k = 1; k < Depth; k++) begin
      dv_side_q[k] <= dv_side_q[k-1];
    end
  end

  // stage 3: entry and exit parameters
  logic               s3_valid_q;
  logic               s3_ok_q;
  coord_t             s3_sx_q, s3_sy_q;
  delta_t             s3_dx_q, s3_dy_q;
  logic signed [RW-1:0] s3_t0_q, s3_t1_q;

  side_t dv_side;
  assign dv_side = dv_side_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= dv_valid_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [RW-1:0] t0, t1, r;
    logic [RF+1:0]        mag;
    logic                 par_ok;
    t0 = '0;
    t1 = TOne;
    par_ok = 1'b1;
    for (int i = 0; i < NumLanes; i++) begin
      mag = dv_side.flags[i].sat ? SatMag : {1'b0, quo[i]};
      r = (dv_side.flags[i].pneg ^ dv_side.flags[i].qneg) ? -RW'(mag) : RW'(mag);
      if (dv_side.flags[i].zero) begin
        if (dv_side.flags[i].qneg) begin
          par_ok = 1'b0;
        end
      end else if (dv_side.flags[i].pneg) begin
        if (r > t0) begin
          t0 = r;
        end
      end else begin
        if (r < t1) begin
          t1 = r;
        end
      end
    end
    s3_ok_q <= par_ok && (t0 <= t1);
    s3_t0_q <= t0;
    s3_t1_q <= t1;
    s3_sx_q <= dv_side.sx;
    s3_sy_q <= dv_side.sy;
    s3_dx_q <= dv_side.dx;
    s3_dy_q <= dv_side.dy;
  end

  // stage 4: products
  logic                 s4_valid_q;
  logic                 s4_ok_q;
  coord_t               s4_sx_q, s4_sy_q;
  logic signed [PW-1:0] s4_prod_q [NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_ok_q      <= s3_ok_q;
    s4_sx_q      <= s3_sx_q;
    s4_sy_q      <= s3_sy_q;
    s4_prod_q[0] <= PW'(s3_dx_q) * PW'(s3_t0_q);
    s4_prod_q[1] <= PW'(s3_dy_q) * PW'(s3_t0_q);
    s4_prod_q[2] <= PW'(s3_dx_q) * PW'(s3_t1_q);
    s4_prod_q[3] <= PW'(s3_dy_q) * PW'(s3_t1_q);
  end

  // stage 5: round, offset and output register
  logic    out_valid_q;
  result_t out_q;
  coord_t  pt [NumLanes];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      logic signed [PW-1:0] sh;
      sh = (s4_prod_q[i] + Half) >>> RF;
      pt[i] = ((i % 2) == 0 ? s4_sx_q : s4_sy_q) + sh[CoordWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.visible         <= s4_ok_q;
    out_q.clipped_start_x <= s4_ok_q ? pt[0] : '0;
    out_q.clipped_start_y <= s4_ok_q ? pt[1] : '0;
    out_q.clipped_end_x   <= s4_ok_q ? pt[2] : '0;
    out_q.clipped_end_y   <= s4_ok_q ? pt[3] : '0;
  end

  assign strobe_o = out_valid_q;
  assign result_o = out_q;

endmodule

`default_nettype wire
